[rtl/oida_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and defaults for the ordered insert/delete array.
package oida_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed word field widths
   localparam int REQ_TYPE_W = 2;
   localparam int IDX_W      = 8;
   localparam int WDATA_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int RDATA_W    = 32;
   localparam int COUNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_GET    = 2'd2,
      REQ_SET    = 2'd3
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic             insert_en;
      logic             delete_en;
      logic             set_en;
      logic [IDX_W-1:0] pos;
   } cell_ctrl_type;

endpackage

[rtl/oida_req_if.sv]
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with the request word.
interface oida_req_if;
   logic                          valid;
   logic                          ready;
   logic [oida_pkg::REQ_TYPE_W-1:0] req_type;
   logic [oida_pkg::IDX_W-1:0]      index;
   logic [oida_pkg::WDATA_W-1:0]    write_value;

   modport source (output valid, output req_type, output index, output write_value,
                   input ready);
   modport sink   (input valid, input req_type, input index, input write_value,
                   output ready);
endinterface

[rtl/oida_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: valid/ready handshake with the result word.
interface oida_rsp_if #(
   parameter int COUNT_WIDTH = oida_pkg::COUNT_W_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [oida_pkg::STATUS_W-1:0] status;
   logic [oida_pkg::RDATA_W-1:0]  read_value;
   logic [COUNT_WIDTH-1:0]        count;

   modport source (output valid, output status, output read_value, output count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input count,
                   output ready);
endinterface

[rtl/oida_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the chain: holds one entry, shifts to or from its neighbors.
module oida_cell #(
   parameter int VALUE_WIDTH = oida_pkg::VALUE_WIDTH_DEFAULT,
   parameter int CELL_INDEX  = 0
) (
   input  logic                    clock,
   input  oida_pkg::cell_ctrl_type ctrl,
   input  logic [VALUE_WIDTH-1:0]  left_value,   // entry of cell below
   input  logic [VALUE_WIDTH-1:0]  right_value,  // entry of cell above
   input  logic [VALUE_WIDTH-1:0]  write_value,
   output logic [VALUE_WIDTH-1:0]  value
);

   localparam logic [oida_pkg::IDX_W-1:0] MY_POS = oida_pkg::IDX_W'(CELL_INDEX);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en) begin
         if (MY_POS > ctrl.pos) begin
            value_in = left_value;
         end else if (MY_POS == ctrl.pos) begin
            value_in = write_value;
         end
      end else if (ctrl.delete_en) begin
         if (MY_POS >= ctrl.pos) begin
            value_in = right_value;
         end
      end else if (ctrl.set_en) begin
         if (MY_POS == ctrl.pos) begin
            value_in = write_value;
         end
      end
   end

   // Payload only: no reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[rtl/ordered_insert_delete_array_core.sv]
`timescale 1ns / 1ps
// Top level of the ordered insert/delete array: control, cell chain and response register.
//
// Ordered array of DEPTH words kept in a chain of cells. Each request word
// (insert, delete, get or set at an index) gets exactly one response word
// carrying a status (ok, invalid index, full), the entry read by a get (zero
// otherwise) and the entry count after the request. Insert clamps its index
// to the count, so any index at or past the end appends. Every cell updates
// in the same cycle, so a request is decoded, applied to the chain and its
// response registered together: one request per cycle when not held off, with
// response valid in the cycle after acceptance. The only thing that holds a
// request off is the response register: a new request is taken when it is
// empty or being drained in the same cycle. Entries are not cleared by reset;
// only the count and response valid are, and no entry at or above the count
// is ever read. Write words wider than VALUE_WIDTH lose their upper bits.
module ordered_insert_delete_array_core #(
   parameter int DEPTH       = oida_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = oida_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   oida_req_if.sink    req_if,
   oida_rsp_if.source  rsp_if
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------------
   // Decode
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic [oida_pkg::IDX_W-1:0]     count_idx;
   logic                           is_full;
   logic                           idx_bad;
   oida_pkg::req_op_type           op;
   oida_pkg::status_type           status_ff;
   oida_pkg::status_type           status_in;
   logic [oida_pkg::RDATA_W-1:0]   read_value_ff;
   logic [oida_pkg::RDATA_W-1:0]   read_value_in;
   oida_pkg::cell_ctrl_type        ctrl;
   logic [VALUE_WIDTH-1:0]         wval;
   logic [VALUE_WIDTH-1:0]         cell_q [DEPTH];
   logic [VALUE_WIDTH-1:0]         rd_sel;

   assign op        = oida_pkg::req_op_type'(req_if.req_type);
   assign count_idx = oida_pkg::IDX_W'(count_ff);
   assign is_full   = (count_ff == FULL_COUNT);
   // count never exceeds DEPTH, so this also covers index >= DEPTH
   assign idx_bad   = (req_if.index >= count_idx);
   // keep low VALUE_WIDTH bits, zero-filled when VALUE_WIDTH is wider
   assign wval      = VALUE_WIDTH'({32'd0, req_if.write_value});
   assign rd_sel    = cell_q[req_if.index[ADDR_W-1:0]];

   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      status_in     = status_ff;
      read_value_in = read_value_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in  = 1'b1;
         status_in     = oida_pkg::ST_OK;
         read_value_in = '0;
         ctrl.pos      = req_if.index;
         case (op)
            oida_pkg::REQ_INSERT: begin
               if (is_full) begin
                  status_in = oida_pkg::ST_FULL;
               end else begin
                  ctrl.insert_en = 1'b1;
                  // clamp: past the end means append
                  if (idx_bad) begin
                     ctrl.pos = count_idx;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            oida_pkg::REQ_DELETE: begin
               if (idx_bad) begin
                  status_in = oida_pkg::ST_BAD_INDEX;
               end else begin
                  ctrl.delete_en = 1'b1;
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            oida_pkg::REQ_GET: begin
               if (idx_bad) begin
                  status_in = oida_pkg::ST_BAD_INDEX;
               end else begin
                  read_value_in = oida_pkg::RDATA_W'(rd_sel);
               end
            end
            oida_pkg::REQ_SET: begin
               if (idx_bad) begin
                  status_in = oida_pkg::ST_BAD_INDEX;
               end else begin
                  ctrl.set_en = 1'b1;
               end
            end
            default: begin
               status_in = oida_pkg::ST_BAD_INDEX;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: cell i shifts from i-1 on insert, from i+1 on delete.
   // End cells recirculate their own word on the missing side.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_w;
      logic [VALUE_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_q[i];
      end else begin : g_mid_l
         assign left_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_q[i];
      end else begin : g_mid_r
         assign right_w = cell_q[i+1];
      end

      oida_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_w),
         .right_value (right_w),
         .write_value (wval),
         .value       (cell_q[i])
      );
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
   end

   // count_ff only moves on accept, which also reloads the response,
   // so it is always the count of the word on display.
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.read_value = read_value_ff;
   assign rsp_if.count      = count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      accept && op == oida_pkg::REQ_INSERT && is_full
      |=> count_ff == $past(count_ff) && status_ff == oida_pkg::ST_FULL)
      else $error("insert into full array changed count");

   a_delete_dec: assert property (@(posedge clock) disable iff (reset)
      accept && op == oida_pkg::REQ_DELETE && !idx_bad
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not drop count");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != oida_pkg::ST_OK |-> read_value_ff == '0)
      else $error("nonzero read word on failed request");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ordered insert/delete array core.
module tb_top;

   localparam int ARRAY_DEPTH  = oida_pkg::DEPTH_DEFAULT;
   localparam int COUNT_WIDTH  = oida_pkg::COUNT_W_DEFAULT;
   localparam int RANDOM_WORDS = 400;
   localparam int QUIET_WORDS  = 60;   // tail of the run with no idling on either side
   localparam int LONG_HOLD    = 80;   // cycles the response side holds off once

   // One expected response word.
   typedef struct packed {
      oida_pkg::status_type            status;
      logic [oida_pkg::RDATA_W-1:0]    read_value;
      logic [COUNT_WIDTH-1:0]          count;
   } rsp_word_type;

   // Shadow copy of the array plus the queue of response words still owed.
   class array_scoreboard;
      logic [oida_pkg::WDATA_W-1:0] slots[ARRAY_DEPTH];
      int unsigned                  fill;
      rsp_word_type                 owed[$];
      int unsigned                  errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      // Apply one accepted request word to the shadow array and queue its response.
      function void note_request(oida_pkg::req_op_type op,
                                 logic [oida_pkg::IDX_W-1:0] idx,
                                 logic [oida_pkg::WDATA_W-1:0] wval);
         rsp_word_type rsp;
         int unsigned  pos;
         rsp.status     = oida_pkg::ST_OK;
         rsp.read_value = '0;
         if (op == oida_pkg::REQ_INSERT) begin
            if (fill >= ARRAY_DEPTH) begin
               rsp.status = oida_pkg::ST_FULL;
            end else begin
               // index past the end appends
               pos = (idx < fill) ? idx : fill;
               for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
               slots[pos] = wval;
               fill++;
            end
         end else if (idx >= fill) begin
            rsp.status = oida_pkg::ST_BAD_INDEX;
         end else begin
            case (op)
               oida_pkg::REQ_DELETE: begin
                  for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
               oida_pkg::REQ_GET: rsp.read_value = slots[idx];
               default: slots[idx] = wval;
            endcase
         end
         rsp.count = fill[COUNT_WIDTH-1:0];
         owed.push_back(rsp);
      endfunction

      // Compare one accepted response word, field by field, with the oldest owed one.
      function void check_response(logic [oida_pkg::STATUS_W-1:0] st,
                                   logic [oida_pkg::RDATA_W-1:0] rv,
                                   logic [COUNT_WIDTH-1:0] cnt);
         rsp_word_type want;
         if (owed.size() == 0) begin
            $display("%0t: response word with none owed, status %0d value %h count %0d",
                     $time, st, rv, cnt);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (st !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, st);
            errors++;
         end
         if (rv !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want.read_value, rv);
            errors++;
         end
         if (cnt !== want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, cnt);
            errors++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   oida_req_if                            req_ch ();
   oida_rsp_if #(.COUNT_WIDTH(COUNT_WIDTH)) rsp_ch ();

   ordered_insert_delete_array_core #(
      .DEPTH       (ARRAY_DEPTH),
      .VALUE_WIDTH (oida_pkg::WDATA_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   array_scoreboard board = new();

   bit quiet_phase     = 1'b0;  // set by the stimulus for the tail of the run
   int long_hold_asks  = 0;     // bumped by the stimulus, served by the response side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side: check every accepted word, then pick ready for the next edge.
   // Ready drops in random bursts, once for a long stretch on request, and
   // never during the quiet tail.
   initial begin
      int gap_left;
      int hold_left;
      int holds_seen;
      gap_left   = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.status, rsp_ch.read_value, rsp_ch.count);
         if (holds_seen != long_hold_asks) begin
            holds_seen = long_hold_asks;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_phase || reset) begin
            rsp_ch.ready <= !reset;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one request word and hold it until the handshake; valid stays high
   // afterwards so back-to-back words need no extra edge.
   task automatic send_request(input oida_pkg::req_op_type op,
                               input logic [oida_pkg::IDX_W-1:0] idx,
                               input logic [oida_pkg::WDATA_W-1:0] wval);
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= op;
      req_ch.index       <= idx;
      req_ch.write_value <= wval;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(op, idx, wval);
   endtask

   // Random sender gap, skipped in the quiet tail.
   task automatic maybe_idle_request();
      int n;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and sit until every owed response word is back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // One random request word. Ops are weighted per segment so the array
   // swings between full and empty; most indexes land inside the array.
   task automatic random_request(input int ins_w, input int del_w);
      oida_pkg::req_op_type          op;
      logic [oida_pkg::IDX_W-1:0]    idx;
      logic [oida_pkg::WDATA_W-1:0]  wval;
      int                            r;
      int                            top;
      r = $urandom_range(0, 99);
      if (r < ins_w)              op = oida_pkg::REQ_INSERT;
      else if (r < ins_w + del_w) op = oida_pkg::REQ_DELETE;
      else if (r[0])              op = oida_pkg::REQ_GET;
      else                        op = oida_pkg::REQ_SET;
      // insert may also address one past the end
      top = (op == oida_pkg::REQ_INSERT) ? board.fill
                                         : ((board.fill > 0) ? board.fill - 1 : 0);
      r = $urandom_range(0, 19);
      if (r < 15)      idx = oida_pkg::IDX_W'($urandom_range(0, top));
      else if (r < 17) idx = oida_pkg::IDX_W'($urandom_range(board.fill, 255));
      else             idx = oida_pkg::IDX_W'($urandom_range(0, 255));
      r = $urandom_range(0, 15);
      if (r == 0)      wval = '0;
      else if (r == 1) wval = '1;
      else             wval = $urandom;
      send_request(op, idx, wval);
   endtask

   initial begin
      int ins_w;
      int del_w;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= oida_pkg::REQ_GET;
      req_ch.index       <= '0;
      req_ch.write_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // every op on the empty array; only insert succeeds
      send_request(oida_pkg::REQ_GET,    8'd0,   32'h0);
      send_request(oida_pkg::REQ_DELETE, 8'd255, 32'h0);
      send_request(oida_pkg::REQ_SET,    8'd0,   32'h1234_5678);
      send_request(oida_pkg::REQ_INSERT, 8'd255, 32'hFFFF_FFFF);  // past the end: append
      send_request(oida_pkg::REQ_INSERT, 8'd0,   32'h0000_0000);  // in front
      send_request(oida_pkg::REQ_INSERT, 8'd1,   32'hA5A5_A5A5);  // in the middle
      send_request(oida_pkg::REQ_GET,    8'd1,   32'h0);
      send_request(oida_pkg::REQ_GET,    8'd3,   32'h0);          // index equal to count
      send_request(oida_pkg::REQ_SET,    8'd2,   32'h5A5A_5A5A);
      // fill to capacity from both ends
      for (int i = 0; i < ARRAY_DEPTH - 3; i++)
         send_request(oida_pkg::REQ_INSERT, (i % 2) ? 8'd255 : 8'd0, $urandom);
      send_request(oida_pkg::REQ_INSERT, 8'd3,   32'hDEAD_BEEF);  // full: nothing changes
      send_request(oida_pkg::REQ_GET,    8'd15,  32'h0);
      send_request(oida_pkg::REQ_GET,    8'd16,  32'h0);
      send_request(oida_pkg::REQ_DELETE, 8'd15,  32'h0);          // last entry
      send_request(oida_pkg::REQ_DELETE, 8'd0,   32'h0);          // first entry

      // --- random part ---
      ins_w = 40;
      del_w = 20;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0) begin
            // new segment: lean toward growing, shrinking or churn
            case ((n / 50) % 3)
               0: begin ins_w = 55; del_w = 15; end
               1: begin ins_w = 15; del_w = 50; end
               default: begin ins_w = 30; del_w = 30; end
            endcase
         end
         // response side holds off long while we keep offering: the
         // response register fills and req ready must drop
         if (n == 100) long_hold_asks++;
         // sender pause until every owed word is back
         if (n == 200) drain_responses();
         if (n == RANDOM_WORDS - QUIET_WORDS) quiet_phase = 1'b1;
         maybe_idle_request();
         random_request(ins_w, del_w);
      end

      // --- wind down ---
      drain_responses();
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/oida_pkg.sv
rtl/oida_req_if.sv
rtl/oida_rsp_if.sv
rtl/oida_cell.sv
rtl/ordered_insert_delete_array_core.sv
tb/tb_top.sv
